>>> src/abb_pkg.sv
// Shared widths, types and job records of the arc bounding box block.
package abb_pkg;

   localparam int COORD_WIDTH  = 32;
   localparam int ROOT_WIDTH   = COORD_WIDTH + 1;
   localparam int SQUARE_WIDTH = 2 * COORD_WIDTH;
   localparam int SUM_WIDTH    = 2 * COORD_WIDTH + 1;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_AW     = $clog2(QUEUE_DEPTH);

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic [COORD_WIDTH-1:0]        mag_type;
   typedef logic [SQUARE_WIDTH-1:0]       square_type;
   typedef logic [SUM_WIDTH-1:0]          sum_type;
   typedef logic [ROOT_WIDTH-1:0]         root_type;

   // One bit per XY edge: set when the edge takes an endpoint value
   // instead of the full-circle value.
   typedef struct packed {
      logic low_x;
      logic high_x;
      logic low_y;
      logic high_y;
   } edge_pick_type;

   // Everything the back end needs besides the radius.
   typedef struct packed {
      coord_type     center_x;
      coord_type     center_y;
      coord_type     low_x;
      coord_type     high_x;
      coord_type     low_y;
      coord_type     high_y;
      coord_type     low_z;
      coord_type     high_z;
      edge_pick_type pick;
   } arc_shape_type;

   typedef struct packed {
      mag_type       dist_x;
      mag_type       dist_y;
      arc_shape_type shape;
   } arc_job_type;

endpackage

>>> src/abb_req_if.sv
// Request channel of the arc bounding box: one arc per transfer.
interface abb_req_if;
   import abb_pkg::*;

   logic      valid;
   logic      ready;
   coord_type start_x;
   coord_type start_y;
   coord_type start_z;
   coord_type end_x;
   coord_type end_y;
   coord_type end_z;
   coord_type center_x;
   coord_type center_y;
   logic      anticlockwise;

   modport source (
      output valid, start_x, start_y, start_z, end_x, end_y, end_z,
             center_x, center_y, anticlockwise,
      input  ready
   );

   modport sink (
      input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
             center_x, center_y, anticlockwise,
      output ready
   );
endinterface

>>> src/abb_rsp_if.sv
// Response channel of the arc bounding box: one box per transfer.
interface abb_rsp_if;
   import abb_pkg::*;

   logic      valid;
   logic      ready;
   coord_type low_x;
   coord_type low_y;
   coord_type low_z;
   coord_type high_x;
   coord_type high_y;
   coord_type high_z;

   modport source (
      output valid, low_x, low_y, low_z, high_x, high_y, high_z,
      input  ready
   );

   modport sink (
      input  valid, low_x, low_y, low_z, high_x, high_y, high_z,
      output ready
   );
endinterface

>>> src/abb_front.sv
// Front end: accepts arcs, orders endpoints and resolves the quadrant case.
module abb_front (
   input  logic                clock,
   input  logic                reset,
   abb_req_if.sink             req_ch,
   output logic                job_valid,
   input  logic                job_ready,
   output abb_pkg::arc_job_type job
);
   import abb_pkg::*;

   // Quadrant codes: first the quadrant of the leading endpoint, then the
   // trailing one. East means x at or right of the centre, north means y at
   // or above it.
   localparam logic [3:0] QC_SW_SW = 4'd0;
   localparam logic [3:0] QC_SW_NW = 4'd1;
   localparam logic [3:0] QC_SW_SE = 4'd2;
   localparam logic [3:0] QC_SW_NE = 4'd3;
   localparam logic [3:0] QC_NW_SW = 4'd4;
   localparam logic [3:0] QC_NW_NW = 4'd5;
   localparam logic [3:0] QC_NW_SE = 4'd6;
   localparam logic [3:0] QC_NW_NE = 4'd7;
   localparam logic [3:0] QC_SE_SW = 4'd8;
   localparam logic [3:0] QC_SE_NW = 4'd9;
   localparam logic [3:0] QC_SE_SE = 4'd10;
   localparam logic [3:0] QC_SE_NE = 4'd11;
   localparam logic [3:0] QC_NE_SW = 4'd12;
   localparam logic [3:0] QC_NE_NW = 4'd13;
   localparam logic [3:0] QC_NE_SE = 4'd14;
   localparam logic [3:0] QC_NE_NE = 4'd15;

   logic        front_valid_ff;
   logic        front_valid_in;
   arc_job_type job_ff;
   arc_job_type job_in;
   logic        req_fire;
   coord_type   a_x;
   coord_type   a_y;
   coord_type   b_x;
   coord_type   b_y;
   coord_type   min_x;
   coord_type   max_x;
   coord_type   min_y;
   coord_type   max_y;
   logic [3:0]  quad;

   function automatic mag_type abs_diff(input coord_type p, input coord_type q);
      logic [COORD_WIDTH:0] d;
      d = {p[COORD_WIDTH-1], p} - {q[COORD_WIDTH-1], q};
      if (d[COORD_WIDTH]) begin
         return COORD_WIDTH'(~d + 1'b1);
      end
      return COORD_WIDTH'(d);
   endfunction

   assign req_ch.ready   = !front_valid_ff || job_ready;
   assign req_fire       = req_ch.valid && req_ch.ready;
   assign front_valid_in = req_fire || (front_valid_ff && !job_ready);
   assign job_valid      = front_valid_ff;
   assign job            = job_ff;

   always_comb begin
      if (req_ch.anticlockwise) begin
         a_x = req_ch.start_x;
         a_y = req_ch.start_y;
         b_x = req_ch.end_x;
         b_y = req_ch.end_y;
      end else begin
         a_x = req_ch.end_x;
         a_y = req_ch.end_y;
         b_x = req_ch.start_x;
         b_y = req_ch.start_y;
      end
      quad  = {a_x >= req_ch.center_x, a_y >= req_ch.center_y,
               b_x >= req_ch.center_x, b_y >= req_ch.center_y};
      min_x = (a_x < b_x) ? a_x : b_x;
      max_x = (a_x > b_x) ? a_x : b_x;
      min_y = (a_y < b_y) ? a_y : b_y;
      max_y = (a_y > b_y) ? a_y : b_y;

      job_in.dist_x          = abs_diff(req_ch.start_x, req_ch.center_x);
      job_in.dist_y          = abs_diff(req_ch.start_y, req_ch.center_y);
      job_in.shape.center_x  = req_ch.center_x;
      job_in.shape.center_y  = req_ch.center_y;
      job_in.shape.low_x     = '0;
      job_in.shape.high_x    = '0;
      job_in.shape.low_y     = '0;
      job_in.shape.high_y    = '0;
      job_in.shape.pick      = '0;
      if (req_ch.start_z < req_ch.end_z) begin
         job_in.shape.low_z  = req_ch.start_z;
         job_in.shape.high_z = req_ch.end_z;
      end else begin
         job_in.shape.low_z  = req_ch.end_z;
         job_in.shape.high_z = req_ch.start_z;
      end

      case (quad)
         QC_SW_SW: begin
            if (b_y < a_y || b_x > a_x) begin
               job_in.shape.low_x  = a_x;
               job_in.shape.high_x = b_x;
               job_in.shape.low_y  = b_y;
               job_in.shape.high_y = a_y;
               job_in.shape.pick   = '1;
            end
         end
         QC_SW_NW: begin
            job_in.shape.low_x      = min_x;
            job_in.shape.pick.low_x = 1'b1;
         end
         QC_SW_SE: begin
            job_in.shape.low_x       = a_x;
            job_in.shape.high_x      = b_x;
            job_in.shape.high_y      = max_y;
            job_in.shape.pick.low_x  = 1'b1;
            job_in.shape.pick.high_x = 1'b1;
            job_in.shape.pick.high_y = 1'b1;
         end
         QC_SW_NE: begin
            job_in.shape.low_x       = a_x;
            job_in.shape.high_y      = b_y;
            job_in.shape.pick.low_x  = 1'b1;
            job_in.shape.pick.high_y = 1'b1;
         end
         QC_NW_SW: begin
            job_in.shape.high_y      = a_y;
            job_in.shape.low_y       = b_y;
            job_in.shape.high_x      = max_x;
            job_in.shape.pick.high_y = 1'b1;
            job_in.shape.pick.low_y  = 1'b1;
            job_in.shape.pick.high_x = 1'b1;
         end
         QC_NW_NW: begin
            if (b_y < a_y || b_x < a_x) begin
               job_in.shape.low_x  = b_x;
               job_in.shape.high_x = a_x;
               job_in.shape.low_y  = b_y;
               job_in.shape.high_y = a_y;
               job_in.shape.pick   = '1;
            end
         end
         QC_NW_SE: begin
            job_in.shape.high_y      = a_y;
            job_in.shape.high_x      = b_x;
            job_in.shape.pick.high_y = 1'b1;
            job_in.shape.pick.high_x = 1'b1;
         end
         QC_NW_NE: begin
            job_in.shape.high_y      = max_y;
            job_in.shape.pick.high_y = 1'b1;
         end
         QC_SE_SW: begin
            job_in.shape.low_y      = min_y;
            job_in.shape.pick.low_y = 1'b1;
         end
         QC_SE_NW: begin
            job_in.shape.low_y      = a_y;
            job_in.shape.low_x      = b_x;
            job_in.shape.pick.low_y = 1'b1;
            job_in.shape.pick.low_x = 1'b1;
         end
         QC_SE_SE: begin
            if (b_y > a_y || b_x > a_x) begin
               job_in.shape.low_x  = a_x;
               job_in.shape.high_x = b_x;
               job_in.shape.low_y  = a_y;
               job_in.shape.high_y = b_y;
               job_in.shape.pick   = '1;
            end
         end
         QC_SE_NE: begin
            job_in.shape.low_y       = a_y;
            job_in.shape.high_y      = b_y;
            job_in.shape.low_x       = min_x;
            job_in.shape.pick.low_y  = 1'b1;
            job_in.shape.pick.high_y = 1'b1;
            job_in.shape.pick.low_x  = 1'b1;
         end
         QC_NE_SW: begin
            job_in.shape.high_x      = a_x;
            job_in.shape.low_y       = b_y;
            job_in.shape.pick.high_x = 1'b1;
            job_in.shape.pick.low_y  = 1'b1;
         end
         QC_NE_NW: begin
            job_in.shape.high_x      = a_x;
            job_in.shape.low_x       = b_x;
            job_in.shape.low_y       = min_y;
            job_in.shape.pick.high_x = 1'b1;
            job_in.shape.pick.low_x  = 1'b1;
            job_in.shape.pick.low_y  = 1'b1;
         end
         QC_NE_SE: begin
            job_in.shape.high_x      = max_x;
            job_in.shape.pick.high_x = 1'b1;
         end
         QC_NE_NE: begin
            if (b_y > a_y || b_x < a_x) begin
               job_in.shape.low_x  = b_x;
               job_in.shape.high_x = a_x;
               job_in.shape.low_y  = a_y;
               job_in.shape.high_y = b_y;
               job_in.shape.pick   = '1;
            end
         end
         default: begin
            job_in.shape.pick = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_valid_ff <= 1'b0;
      end else begin
         front_valid_ff <= front_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         job_ff <= job_in;
      end
   end

endmodule

>>> src/abb_queue.sv
// Short job queue between the front end and the back end.
module abb_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  abb_pkg::arc_job_type push_job,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output abb_pkg::arc_job_type pop_job
);
   import abb_pkg::*;

   arc_job_type           slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff;
   logic [QUEUE_AW-1:0]   wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff;
   logic [QUEUE_AW-1:0]   rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff;
   logic [QUEUE_AW:0]     count_in;
   logic                  push;
   logic                  pop;

   assign push_ready = count_ff != (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + (QUEUE_AW + 1)'(1);
         2'b01:   count_in = count_ff - (QUEUE_AW + 1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   // The fill level never passes the number of slots.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
      else $error("job queue overfilled");

   // A job written into an empty queue is at the head on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (push && count_ff == '0) |=> (pop_valid && pop_job == $past(push_job)))
      else $error("job queue head does not match the job just written");

endmodule

>>> src/abb_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module abb_isqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  abb_pkg::sum_type   sum,
   output logic               out_valid,
   output abb_pkg::root_type  root
);
   import abb_pkg::*;

   localparam int TRIAL_WIDTH = 2 * ROOT_WIDTH;

   logic [ROOT_WIDTH-1:0] valid_ff;
   sum_type               rem_ff  [ROOT_WIDTH];
   root_type              root_ff [ROOT_WIDTH];

   // Each stage keeps rem = sum - root^2 and tries the next lower root bit.
   for (genvar k = 0; k < ROOT_WIDTH; k++) begin : g_stage
      localparam int B = ROOT_WIDTH - 1 - k;
      sum_type                rem_src;
      root_type               root_src;
      sum_type                rem_in;
      root_type               root_in;
      logic [TRIAL_WIDTH-1:0] trial;
      logic                   take;

      if (k == 0) begin : g_first
         assign rem_src  = sum;
         assign root_src = '0;
      end else begin : g_next
         assign rem_src  = rem_ff[k-1];
         assign root_src = root_ff[k-1];
      end

      assign trial   = (TRIAL_WIDTH'(root_src) << (B + 1)) | (TRIAL_WIDTH'(1) << (2 * B));
      assign take    = TRIAL_WIDTH'(rem_src) >= trial;
      assign rem_in  = take ? SUM_WIDTH'(TRIAL_WIDTH'(rem_src) - trial) : rem_src;
      assign root_in = take ? (root_src | (ROOT_WIDTH'(1) << B)) : root_src;

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[ROOT_WIDTH-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[ROOT_WIDTH-1];
   assign root      = root_ff[ROOT_WIDTH-1];

   // A finished root leaves a remainder of at most twice the root, so the
   // next integer up would overshoot the sum.
   assert property (@(posedge clock) disable iff (reset)
      out_valid |-> (TRIAL_WIDTH'(rem_ff[ROOT_WIDTH-1]) <= (TRIAL_WIDTH'(root) << 1)))
      else $error("square root remainder out of range");

endmodule

>>> src/abb_back.sv
// Back end: radius from squared distances, circle edges and box selection.
module abb_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  abb_pkg::arc_job_type job,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output abb_pkg::coord_type   low_x,
   output abb_pkg::coord_type   low_y,
   output abb_pkg::coord_type   low_z,
   output abb_pkg::coord_type   high_x,
   output abb_pkg::coord_type   high_y,
   output abb_pkg::coord_type   high_z
);
   import abb_pkg::*;

   localparam int EDGE_WIDTH = COORD_WIDTH + 2;

   logic          en;
   logic          take;
   logic          sq_valid_ff;
   logic          sum_valid_ff;
   logic          edge_valid_ff;
   logic          out_valid_ff;
   logic          root_valid;
   root_type      root;
   square_type    dx_sq_ff;
   square_type    dy_sq_ff;
   sum_type       sum_ff;
   arc_shape_type sq_shape_ff;
   arc_shape_type sum_shape_ff;
   arc_shape_type shape_line_ff [ROOT_WIDTH];
   arc_shape_type edge_shape_ff;
   coord_type     circ_low_x_ff;
   coord_type     circ_high_x_ff;
   coord_type     circ_low_y_ff;
   coord_type     circ_high_y_ff;
   coord_type     low_x_ff;
   coord_type     low_y_ff;
   coord_type     low_z_ff;
   coord_type     high_x_ff;
   coord_type     high_y_ff;
   coord_type     high_z_ff;
   logic signed [EDGE_WIDTH-1:0] rad_w;
   logic signed [EDGE_WIDTH-1:0] ctr_x_w;
   logic signed [EDGE_WIDTH-1:0] ctr_y_w;

   function automatic coord_type sat_coord(input logic signed [EDGE_WIDTH-1:0] v);
      if (v[EDGE_WIDTH-1:COORD_WIDTH-1] == '0 || v[EDGE_WIDTH-1:COORD_WIDTH-1] == '1) begin
         return coord_type'(v[COORD_WIDTH-1:0]);
      end
      if (v[EDGE_WIDTH-1]) begin
         return coord_type'({1'b1, {(COORD_WIDTH - 1){1'b0}}});
      end
      return coord_type'({1'b0, {(COORD_WIDTH - 1){1'b1}}});
   endfunction

   // The whole pipeline moves together whenever the output slot is free
   // or being drained.
   assign en        = !out_valid_ff || rsp_ready;
   assign job_ready = en;
   assign take      = job_valid && en;

   assign rad_w   = signed'({1'b0, root});
   assign ctr_x_w = signed'({{2{shape_line_ff[ROOT_WIDTH-1].center_x[COORD_WIDTH-1]}},
                             shape_line_ff[ROOT_WIDTH-1].center_x});
   assign ctr_y_w = signed'({{2{shape_line_ff[ROOT_WIDTH-1].center_y[COORD_WIDTH-1]}},
                             shape_line_ff[ROOT_WIDTH-1].center_y});

   abb_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sum_valid_ff),
      .sum       (sum_ff),
      .out_valid (root_valid),
      .root      (root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff   <= 1'b0;
         sum_valid_ff  <= 1'b0;
         edge_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (en) begin
         sq_valid_ff   <= take;
         sum_valid_ff  <= sq_valid_ff;
         edge_valid_ff <= root_valid;
         out_valid_ff  <= edge_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx_sq_ff    <= SQUARE_WIDTH'(job.dist_x) * SQUARE_WIDTH'(job.dist_x);
         dy_sq_ff    <= SQUARE_WIDTH'(job.dist_y) * SQUARE_WIDTH'(job.dist_y);
         sq_shape_ff <= job.shape;

         sum_ff       <= SUM_WIDTH'(dx_sq_ff) + SUM_WIDTH'(dy_sq_ff);
         sum_shape_ff <= sq_shape_ff;

         shape_line_ff[0] <= sum_shape_ff;
         for (int k = 1; k < ROOT_WIDTH; k++) begin
            shape_line_ff[k] <= shape_line_ff[k-1];
         end

         edge_shape_ff  <= shape_line_ff[ROOT_WIDTH-1];
         circ_low_x_ff  <= sat_coord(ctr_x_w - rad_w);
         circ_high_x_ff <= sat_coord(ctr_x_w + rad_w);
         circ_low_y_ff  <= sat_coord(ctr_y_w - rad_w);
         circ_high_y_ff <= sat_coord(ctr_y_w + rad_w);

         low_x_ff  <= edge_shape_ff.pick.low_x  ? edge_shape_ff.low_x  : circ_low_x_ff;
         high_x_ff <= edge_shape_ff.pick.high_x ? edge_shape_ff.high_x : circ_high_x_ff;
         low_y_ff  <= edge_shape_ff.pick.low_y  ? edge_shape_ff.low_y  : circ_low_y_ff;
         high_y_ff <= edge_shape_ff.pick.high_y ? edge_shape_ff.high_y : circ_high_y_ff;
         low_z_ff  <= edge_shape_ff.low_z;
         high_z_ff <= edge_shape_ff.high_z;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign low_x     = low_x_ff;
   assign low_y     = low_y_ff;
   assign low_z     = low_z_ff;
   assign high_x    = high_x_ff;
   assign high_y    = high_y_ff;
   assign high_z    = high_z_ff;

   // The z span always comes out ordered.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (low_z_ff <= high_z_ff))
      else $error("box z span is reversed");

endmodule

>>> src/arc_bounding_box_top.sv
// Top level of the arc bounding box block: front end, job queue, back end.
//
//   Channel  Direction  Handshake      Payload
//   req_ch   in         valid / ready  start, end (x, y, z), center (x, y), anticlockwise
//   rsp_ch   out        valid / ready  low (x, y, z), high (x, y, z)
//
// One arc is taken per cycle and one box leaves per cycle in steady state while rsp_ch is ready.
// An arc passes the front register, the queue, the square and sum registers,
// the square root pipeline (one stage per root bit) and the edge and output registers.
// Reset is synchronous and clears only the valid bits, queue pointers and queue fill count.
// A stall on rsp_ch freezes the back end; the queue and the front register
// keep taking arcs until the queue fills, and only then does req_ch.ready drop.
module arc_bounding_box_top (
   input  logic       clock,
   input  logic       reset,
   abb_req_if.sink    req_ch,
   abb_rsp_if.source  rsp_ch
);
   import abb_pkg::*;

   // Front register to queue.
   logic        front_valid;
   logic        front_ready;
   arc_job_type front_job;

   // Queue head to back end.
   logic        head_valid;
   logic        head_ready;
   arc_job_type head_job;

   // The front end orders the endpoints, finds the quadrant case and
   // computes the distances from the centre that feed the radius.
   abb_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job       (front_job)
   );

   // The queue decouples the two halves so that a short stall on the result
   // side does not reach back to the request side.
   abb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (head_valid),
      .pop_ready  (head_ready),
      .pop_job    (head_job)
   );

   // The back end squares, sums, takes the root and builds the final box.
   abb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (head_valid),
      .job_ready (head_ready),
      .job       (head_job),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .low_x     (rsp_ch.low_x),
      .low_y     (rsp_ch.low_y),
      .low_z     (rsp_ch.low_z),
      .high_x    (rsp_ch.high_x),
      .high_y    (rsp_ch.high_y),
      .high_z    (rsp_ch.high_z)
   );

endmodule
